FILE: hdl/oets_pkg.sv
// ----------------------------------------------------------------------------
// oets_pkg: shared constants and helpers for the transposition sorter
// Capacity, index widths and the float ordering key.
// ----------------------------------------------------------------------------
package oets_pkg;

  localparam int unsigned MaxElements = 64;
  localparam int unsigned CntW        = $clog2(MaxElements + 1);

  // Float bits to an unsigned key that orders like the float value.
  function automatic logic [31:0] order_key(input logic [31:0] bits);
    if (bits[31]) begin
      order_key = ~bits;
    end else begin
      order_key = bits | 32'h8000_0000;
    end
  endfunction

  typedef struct packed {
    logic load;    // shift a new element in at the top
    logic shift;   // emit: every cell takes its upper neighbor
    logic phase;   // compare-exchange phase active
    logic parity;  // 0: pairs 0-1, 2-3 ... ; 1: pairs 1-2, 3-4 ...
  } cell_ctrl_t;

endpackage

FILE: hdl/oets_cell.sv
// ----------------------------------------------------------------------------
// oets_cell: one storage cell of the sort chain
// Holds one element; loads, shifts down, or swaps with a neighbor.
// ----------------------------------------------------------------------------
module oets_cell (
  input  logic                clk_i,
  input  oets_pkg::cell_ctrl_t ctrl_i,
  input  logic                even_i,      // this cell has even index
  input  logic                active_i,    // this cell index < fill count
  input  logic                up_valid_i,  // upper neighbor index < fill count
  input  logic                dn_valid_i,  // lower neighbor exists
  input  logic                is_top_i,    // cell takes the loaded value
  input  logic [31:0]         load_val_i,
  input  logic [31:0]         up_val_i,
  input  logic [31:0]         dn_val_i,
  output logic [31:0]         val_o,
  output logic                swap_o       // this cell is the low side of a swap
);

  logic [31:0] val_q, val_d;
  logic        lo_side, hi_side, swap_lo, swap_hi;

  always_comb begin
    // low side of a pair when parity matches own index parity
    lo_side = ctrl_i.phase && (even_i != ctrl_i.parity);
    hi_side = ctrl_i.phase && (even_i == ctrl_i.parity);
    swap_lo = lo_side && active_i && up_valid_i &&
              (oets_pkg::order_key(val_q) > oets_pkg::order_key(up_val_i));
    swap_hi = hi_side && active_i && dn_valid_i &&
              (oets_pkg::order_key(dn_val_i) > oets_pkg::order_key(val_q));
    val_d = val_q;
    if (ctrl_i.load) begin
      if (is_top_i) val_d = load_val_i;
    end else if (ctrl_i.shift) begin
      val_d = up_val_i;
    end else if (swap_lo) begin
      val_d = up_val_i;
    end else if (swap_hi) begin
      val_d = dn_val_i;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign val_o  = val_q;
  assign swap_o = swap_lo;

endmodule

FILE: hdl/odd_even_transposition_sort.sv
// ----------------------------------------------------------------------------
// odd_even_transposition_sort: float list sorter on a chain of cells
// Loads a list, sorts it by odd-even transposition, emits it ascending.
// ----------------------------------------------------------------------------
// Input beats (value_i, is_last_i) fill the chain at one per cycle; elements
// past 64 are dropped and flag overflow on every output of that list.
// The beat with is_last_i set ends loading. The chain then runs one
// compare-exchange phase per cycle, all pairs of a phase in parallel, and
// stops after an even-plus-odd round with no exchange. The list then leaves
// from cell 0, one beat per cycle, end_of_list_o on the last beat. Input is
// stalled from is_last until the last output beat is taken. A stalled
// output holds; the chain waits.
// Reset clears the control state; cell contents are left as they are.
// ----------------------------------------------------------------------------
module odd_even_transposition_sort (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        stall_o,
  input  logic [31:0] value_i,
  input  logic        is_last_i,
  output logic        valid_o,
  input  logic        stall_i,
  output logic [31:0] sorted_value_o,
  output logic        end_of_list_o,
  output logic        overflow_o
);

  localparam int unsigned N = oets_pkg::MaxElements;

  typedef enum logic [1:0] {StLoad, StSort, StEmit} state_e;

  state_e                    state_q;
  logic [oets_pkg::CntW-1:0] fill_q;
  logic                      ovf_q, parity_q, exch_q;

  oets_pkg::cell_ctrl_t ctrl;
  logic [31:0]          vals [N];
  logic [N-1:0]         swaps;
  logic                 in_acc, out_acc;

  assign in_acc  = valid_i && !stall_o;
  assign out_acc = valid_o && !stall_i;
  assign stall_o = (state_q != StLoad);
  assign valid_o = (state_q == StEmit);

  always_comb begin
    ctrl.load   = in_acc && (fill_q != oets_pkg::CntW'(N));
    ctrl.shift  = out_acc;
    ctrl.phase  = (state_q == StSort);
    ctrl.parity = parity_q;
  end

  for (genvar g = 0; g < N; g++) begin : g_cell
    localparam logic [oets_pkg::CntW-1:0] Idx = oets_pkg::CntW'(g);
    oets_cell u_cell (
      .clk_i,
      .ctrl_i     (ctrl),
      .even_i     ((g % 2) == 0),
      .active_i   (Idx < fill_q),
      .up_valid_i ((g < N - 1) && (Idx + 1'b1 < fill_q)),
      .dn_valid_i (g > 0),
      .is_top_i   (Idx == fill_q),
      .load_val_i (value_i),
      .up_val_i   (vals[(g < N - 1) ? g + 1 : g]),
      .dn_val_i   (vals[(g > 0) ? g - 1 : g]),
      .val_o      (vals[g]),
      .swap_o     (swaps[g])
    );
  end

  assign sorted_value_o = vals[0];
  assign end_of_list_o  = (fill_q == oets_pkg::CntW'(1));
  assign overflow_o     = ovf_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StLoad;
      fill_q   <= '0;
      ovf_q    <= 1'b0;
      parity_q <= 1'b0;
      exch_q   <= 1'b0;
    end else begin
      unique case (state_q)
        StLoad: begin
          if (in_acc) begin
            if (ctrl.load) fill_q <= fill_q + 1'b1;
            else           ovf_q  <= 1'b1;
            if (is_last_i) begin
              state_q  <= StSort;
              parity_q <= 1'b0;
              exch_q   <= 1'b0;
            end
          end
        end
        StSort: begin
          parity_q <= !parity_q;
          if (!parity_q) begin
            exch_q <= |swaps;
          end else begin
            exch_q <= 1'b0;
            if (!exch_q && !(|swaps)) state_q <= StEmit;
          end
        end
        StEmit: begin
          if (out_acc) begin
            fill_q <= fill_q - 1'b1;
            if (fill_q == oets_pkg::CntW'(1)) begin
              state_q <= StLoad;
              ovf_q   <= 1'b0;
            end
          end
        end
        default: state_q <= StLoad;
      endcase
    end
  end

endmodule

FILE: hdl/oets_checker.sv
// ----------------------------------------------------------------------------
// oets_checker: port-level checks for the transposition sorter
// Watches ordering, list end and handshake behavior.
// ----------------------------------------------------------------------------
module oets_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        stall_o,
  input logic        valid_o,
  input logic        stall_i,
  input logic [31:0] sorted_value_o,
  input logic        end_of_list_o,
  input logic        overflow_o
);

  // consecutive beats of one list come out ascending
  a_ascending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !stall_i && !end_of_list_o) ##1 (valid_o && !stall_i) |->
    oets_pkg::order_key($past(sorted_value_o)) <= oets_pkg::order_key(sorted_value_o))
    else $error("output not ascending");

  // overflow is constant across a list
  a_ovf_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !stall_i && !end_of_list_o) ##1 valid_o |-> $stable(overflow_o))
    else $error("overflow changed within list");

  // no input taken while results are out
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> stall_o)
    else $error("input open during emit");

  // stalled output holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && stall_i |=> valid_o && $stable(sorted_value_o))
    else $error("stalled output changed");

endmodule

bind odd_even_transposition_sort oets_checker u_oets_checker (.*);
